### rtl/unordered_min_priority_queue_unit_macros.svh
// Assertion macros used by the queue datapath.
`ifndef UNORDERED_MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define UNORDERED_MIN_PRIORITY_QUEUE_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked assertion that is disabled while reset is asserted.
`define UMPQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define UMPQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define UMPQ_ASSERT(lbl, clk, rstn, prop, msg)

`define UMPQ_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### rtl/umpq_pkg.sv
// Package with types, codes and the microcode table of the priority queue.
package umpq_pkg;

  // Store geometry.
  localparam int unsigned Depth   = 64;
  localparam int unsigned AddrW   = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned ValW    = 32;
  localparam int unsigned ReqW    = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  typedef logic [ReqW-1:0]    req_t;
  typedef logic [StatusW-1:0] status_t;
  typedef logic [AddrW-1:0]   addr_t;
  typedef logic [CntW-1:0]    cnt_t;
  typedef logic [ValW-1:0]    val_t;

  // Request codes.
  localparam req_t ReqInsert    = 3'd0;
  localparam req_t ReqRemove    = 3'd1;
  localparam req_t ReqPeek      = 3'd2;
  localparam req_t ReqDeleteAll = 3'd3;
  localparam req_t ReqContains  = 3'd4;
  localparam req_t ReqClear     = 3'd5;

  // Status codes.
  localparam status_t StatusOk    = 2'd0;
  localparam status_t StatusEmpty = 2'd1;
  localparam status_t StatusFull  = 2'd2;

  // Microprogram addresses.
  typedef logic [3:0] upc_t;
  localparam upc_t UpcIdle     = 4'd0;
  localparam upc_t UpcDispatch = 4'd1;
  localparam upc_t UpcInsert   = 4'd2;
  localparam upc_t UpcClear    = 4'd3;
  localparam upc_t UpcMinChk   = 4'd4;
  localparam upc_t UpcMinScan  = 4'd5;
  localparam upc_t UpcMinLast  = 4'd6;
  localparam upc_t UpcMinMove  = 4'd7;
  localparam upc_t UpcDelScan  = 4'd8;
  localparam upc_t UpcDelEnd   = 4'd9;
  localparam upc_t UpcConScan  = 4'd10;
  localparam upc_t UpcResp     = 4'd11;

  // Datapath operations selected by a control word.
  typedef enum logic [3:0] {
    OpNone,
    OpAccept,
    OpInsert,
    OpClear,
    OpChkEmpty,
    OpScan,
    OpLastRd,
    OpMove,
    OpDelEnd,
    OpResp
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    CondAlways,
    CondAccept,
    CondEmpty,
    CondScanDone,
    CondNotRemove,
    CondOutFree,
    CondDispatch
  } cond_e;

  // One control word: operation, jump condition, jump target and whether
  // the step repeats while the condition is false.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  target;
    logic  hold;
  } ucw_t;

  // Status flags the datapath hands to the sequencer.
  typedef struct packed {
    logic accept;
    logic empty;
    logic scan_done;
    logic is_remove;
    logic out_free;
    req_t req;
  } dp_flags_t;

  // Microcode table.
  function automatic ucw_t ucode_rom(upc_t pc);
    ucw_t w;
    case (pc)
      UpcIdle:     w = '{OpAccept,   CondAccept,    UpcDispatch, 1'b1};
      UpcDispatch: w = '{OpNone,     CondDispatch,  UpcResp,     1'b0};
      UpcInsert:   w = '{OpInsert,   CondAlways,    UpcResp,     1'b0};
      UpcClear:    w = '{OpClear,    CondAlways,    UpcResp,     1'b0};
      UpcMinChk:   w = '{OpChkEmpty, CondEmpty,     UpcResp,     1'b0};
      UpcMinScan:  w = '{OpScan,     CondScanDone,  UpcMinLast,  1'b1};
      UpcMinLast:  w = '{OpLastRd,   CondNotRemove, UpcResp,     1'b0};
      UpcMinMove:  w = '{OpMove,     CondAlways,    UpcResp,     1'b0};
      UpcDelScan:  w = '{OpScan,     CondScanDone,  UpcDelEnd,   1'b1};
      UpcDelEnd:   w = '{OpDelEnd,   CondAlways,    UpcResp,     1'b0};
      UpcConScan:  w = '{OpScan,     CondScanDone,  UpcResp,     1'b1};
      UpcResp:     w = '{OpResp,     CondOutFree,   UpcIdle,     1'b1};
      default:     w = '{OpNone,     CondAlways,    UpcIdle,     1'b0};
    endcase
    return w;
  endfunction

  // Entry point of the routine for each request code.
  function automatic upc_t dispatch_target(req_t req);
    upc_t t;
    case (req)
      ReqInsert:    t = UpcInsert;
      ReqRemove:    t = UpcMinChk;
      ReqPeek:      t = UpcMinChk;
      ReqDeleteAll: t = UpcDelScan;
      ReqContains:  t = UpcConScan;
      ReqClear:     t = UpcClear;
      default:      t = UpcResp;
    endcase
    return t;
  endfunction

endpackage

### rtl/umpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module umpq_ram #(
  parameter int unsigned DataW = 32,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/umpq_seq.sv
// Microcode sequencer: step counter, control table lookup and jump logic.
module umpq_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  umpq_pkg::dp_flags_t  flags_i,
  output umpq_pkg::ucw_t       ucw_o
);
  import umpq_pkg::*;

  upc_t pc_q, pc_d;
  ucw_t ucw;
  logic take;
  upc_t target;

  // Control word of the current step.
  always_comb begin
    ucw = ucode_rom(pc_q);
  end

  assign ucw_o = ucw;

  // Condition select and next step.
  always_comb begin
    case (ucw.cond)
      CondAlways:    take = 1'b1;
      CondAccept:    take = flags_i.accept;
      CondEmpty:     take = flags_i.empty;
      CondScanDone:  take = flags_i.scan_done;
      CondNotRemove: take = !flags_i.is_remove;
      CondOutFree:   take = flags_i.out_free;
      CondDispatch:  take = 1'b1;
      default:       take = 1'b1;
    endcase
    target = (ucw.cond == CondDispatch) ? dispatch_target(flags_i.req) : ucw.target;
    if (take) begin
      pc_d = target;
    end else if (ucw.hold) begin
      pc_d = pc_q;
    end else begin
      pc_d = pc_q + upc_t'(1);
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UpcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

### rtl/umpq_dp.sv
// Datapath: request registers, scan pointers, minimum tracker, entry RAM and result register.
`include "unordered_min_priority_queue_unit_macros.svh"

module umpq_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  umpq_pkg::ucw_t                    ucw_i,
  output umpq_pkg::dp_flags_t               flags_o,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [umpq_pkg::ReqW-1:0]         req_type_i,
  input  logic signed [umpq_pkg::ValW-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [umpq_pkg::ValW-1:0]  result_value_o,
  output logic                              hit_o,
  output logic [umpq_pkg::StatusW-1:0]      status_o,
  output logic [umpq_pkg::CountW-1:0]       count_o
);
  import umpq_pkg::*;

  localparam int unsigned CntExtW = CntW + CountW;

  // Control state.
  cnt_t    count_q, count_d;
  cnt_t    ptr_q, ptr_d;
  cnt_t    kept_q, kept_d;
  logic    rd_vld_q, rd_vld_d;
  logic    have_best_q, have_best_d;
  logic    hit_q, hit_d;
  status_t status_q, status_d;
  req_t    req_q, req_d;
  logic    out_valid_q, out_valid_d;

  // Payload registers.
  val_t    val_q, val_d;
  val_t    best_q, best_d;
  addr_t   best_slot_q, best_slot_d;
  addr_t   rd_slot_q, rd_slot_d;
  val_t    out_value_q, out_value_d;
  logic    out_hit_q, out_hit_d;
  status_t out_status_q, out_status_d;
  logic [CountW-1:0] out_count_q, out_count_d;

  // RAM ports.
  logic    we;
  addr_t   waddr;
  val_t    wdata;
  addr_t   raddr;
  val_t    rdata;

  logic    accept;
  logic    out_free;
  logic    issue;
  logic    is_min_req;
  cnt_t    last_idx;
  logic [CntExtW-1:0] count_ext;

  umpq_ram #(
    .DataW (ValW),
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Handshake helpers.
  assign in_stall_o = (ucw_i.op != OpAccept);
  assign accept     = in_valid_i && (ucw_i.op == OpAccept);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign issue      = (ptr_q < count_q);
  assign last_idx   = count_q - cnt_t'(1);
  assign is_min_req = (req_q == ReqRemove) || (req_q == ReqPeek);
  assign count_ext  = CntExtW'(count_q);

  // Flags for the sequencer.
  always_comb begin
    flags_o.accept    = accept;
    flags_o.empty     = (count_q == '0);
    flags_o.scan_done = (ptr_q == count_q) && !rd_vld_q;
    flags_o.is_remove = (req_q == ReqRemove);
    flags_o.out_free  = out_free;
    flags_o.req       = req_q;
  end

  // Operation decode and scan processing.
  always_comb begin
    count_d      = count_q;
    ptr_d        = ptr_q;
    kept_d       = kept_q;
    rd_vld_d     = 1'b0;
    have_best_d  = have_best_q;
    hit_d        = hit_q;
    status_d     = status_q;
    req_d        = req_q;
    val_d        = val_q;
    best_d       = best_q;
    best_slot_d  = best_slot_q;
    rd_slot_d    = rd_slot_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_value_d  = out_value_q;
    out_hit_d    = out_hit_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    we           = 1'b0;
    waddr        = kept_q[AddrW-1:0];
    wdata        = rdata;
    raddr        = ptr_q[AddrW-1:0];

    case (ucw_i.op)
      OpAccept: begin
        if (accept) begin
          req_d       = req_type_i;
          val_d       = value_i;
          ptr_d       = '0;
          kept_d      = '0;
          hit_d       = 1'b0;
          status_d    = StatusOk;
          have_best_d = 1'b0;
        end
      end
      OpInsert: begin
        if (count_q < cnt_t'(Depth)) begin
          we      = 1'b1;
          waddr   = count_q[AddrW-1:0];
          wdata   = val_q;
          count_d = count_q + cnt_t'(1);
          hit_d   = 1'b1;
        end else begin
          status_d = StatusFull;
        end
      end
      OpClear: begin
        count_d = '0;
      end
      OpChkEmpty: begin
        if (count_q == '0) begin
          status_d = StatusEmpty;
        end
      end
      OpScan: begin
        raddr     = ptr_q[AddrW-1:0];
        rd_vld_d  = issue;
        rd_slot_d = ptr_q[AddrW-1:0];
        ptr_d     = ptr_q + cnt_t'(issue);
      end
      OpLastRd: begin
        raddr = last_idx[AddrW-1:0];
      end
      OpMove: begin
        we      = 1'b1;
        waddr   = best_slot_q;
        wdata   = rdata;
        count_d = last_idx;
      end
      OpDelEnd: begin
        count_d = kept_q;
      end
      OpResp: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_value_d  = (is_min_req && (status_q == StatusOk)) ? best_q : '0;
          out_hit_d    = hit_q;
          out_status_d = status_q;
          out_count_d  = count_ext[CountW-1:0];
        end
      end
      default: begin
      end
    endcase

    // Entry read by a scan step in the previous cycle arrives here.
    if (rd_vld_q) begin
      case (req_q)
        ReqRemove, ReqPeek: begin
          if (!have_best_q || ($signed(rdata) < $signed(best_q))) begin
            best_d      = rdata;
            best_slot_d = rd_slot_q;
            have_best_d = 1'b1;
          end
        end
        ReqDeleteAll: begin
          // Survivors are packed down behind the read pointer.
          if (rdata != val_q) begin
            we     = 1'b1;
            waddr  = kept_q[AddrW-1:0];
            wdata  = rdata;
            kept_d = kept_q + cnt_t'(1);
          end else begin
            hit_d = 1'b1;
          end
        end
        ReqContains: begin
          if (rdata == val_q) begin
            hit_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      kept_q      <= '0;
      rd_vld_q    <= 1'b0;
      have_best_q <= 1'b0;
      hit_q       <= 1'b0;
      status_q    <= StatusOk;
      req_q       <= ReqInsert;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      kept_q      <= kept_d;
      rd_vld_q    <= rd_vld_d;
      have_best_q <= have_best_d;
      hit_q       <= hit_d;
      status_q    <= status_d;
      req_q       <= req_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    best_q       <= best_d;
    best_slot_q  <= best_slot_d;
    rd_slot_q    <= rd_slot_d;
    out_value_q  <= out_value_d;
    out_hit_q    <= out_hit_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign hit_o          = out_hit_q;
  assign status_o       = out_status_q;
  assign count_o        = out_count_q;

  // Checks on the datapath.
  `UMPQ_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= cnt_t'(Depth), "entry count above depth")
  `UMPQ_ASSERT(a_kept_behind, clk_i, rst_ni, kept_q <= ptr_q, "compaction overtook the read pointer")
  `UMPQ_ASSERT(a_rd_from_scan, clk_i, rst_ni, rd_vld_q |-> $past(ucw_i.op == OpScan), "read data flagged outside a scan")
  `UMPQ_ASSERT(a_move_nonempty, clk_i, rst_ni, (ucw_i.op == OpMove) |-> (have_best_q && (count_q != '0)), "move step without a minimum")

endmodule

### rtl/unordered_min_priority_queue_unit.sv
// Top level of the unsorted-store minimum priority queue.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   req_type_i, value_i
//   out      output     out_valid_o / out_stall_i result_value_o, hit_o, status_o, count_o
//
// Insert and clear run their operation step between dispatch and the response step; unused
// codes go from dispatch straight to the response step. Scans read one entry per cycle
// through the single RAM read port; remove and peek first check for an empty queue and
// skip the scan on an empty one.
// Reset clears the entry count and the control registers; the RAM is never swept.
// A new request is taken only at the idle step; a finished result waits in the output
// register while out_stall_i is high, and the next request may be taken meanwhile.
module unordered_min_priority_queue_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [umpq_pkg::ReqW-1:0]         req_type_i,
  input  logic signed [umpq_pkg::ValW-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [umpq_pkg::ValW-1:0]  result_value_o,
  output logic                              hit_o,
  output logic [umpq_pkg::StatusW-1:0]      status_o,
  output logic [umpq_pkg::CountW-1:0]       count_o
);
  import umpq_pkg::*;

  ucw_t      ucw;
  dp_flags_t flags;

  umpq_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ucw_o   (ucw)
  );

  umpq_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ucw_i          (ucw),
    .flags_o        (flags),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .hit_o          (hit_o),
    .status_o       (status_o),
    .count_o        (count_o)
  );

endmodule
